FILE: hdl/teaa_pkg.sv
// Shared types and constants for the two-ended arena allocator.
`default_nettype none

package teaa_pkg;

    localparam int unsigned DEFAULT_MAX_POOL_BYTES = 65536;
    localparam int unsigned DEFAULT_ALIGN_BYTES    = 16;

    localparam int SIZE_W = 17;
    localparam int OFF_W  = 16;
    localparam int UNIT_W = 18;
    localparam int EXT_W  = 19;

    typedef enum logic [1:0] {
        MODE_ALLOC_FRONT,
        MODE_ALLOC_BACK,
        MODE_REALLOC,
        MODE_RESET
    } teaa_mode_t;

    typedef struct packed {
        teaa_mode_t              mode;
        logic [UNIT_W-1:0]       units;
        logic [OFF_W-1:0]        old_offset;
        logic [SIZE_W-1:0]       prior_size;
        logic                    keep_present;
    } teaa_req_t;

    typedef struct packed {
        logic                    success;
        logic [SIZE_W-1:0]       offset;
        logic                    copy_needed;
        logic [OFF_W-1:0]        copy_from;
        logic [SIZE_W-1:0]       copy_length;
    } teaa_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/teaa_in_stage.sv
// Request input register with the size converted to alignment units.
`default_nettype none

module teaa_in_stage #(
    parameter int unsigned ALIGN_BYTES = teaa_pkg::DEFAULT_ALIGN_BYTES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [1:0]                 mode,
    input  wire logic [teaa_pkg::SIZE_W-1:0] request_size,
    input  wire logic [teaa_pkg::OFF_W-1:0]  old_offset,
    input  wire logic [teaa_pkg::SIZE_W-1:0] prior_size,
    input  wire logic                       keep_present,
    input  wire logic                       core_ready,
    output logic                            stage_valid,
    output teaa_pkg::teaa_req_t             stage_req
);
    import teaa_pkg::*;

    localparam int SHIFT   = 25;
    localparam int RECIP_W = 26;
    localparam int PROD_W  = UNIT_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [UNIT_W-1:0] ROUND_ADD = UNIT_W'(ALIGN_BYTES - 1);

    logic              valid_reg;
    logic              valid_next;
    teaa_req_t         req_reg;
    teaa_req_t         req_next;
    logic              load;
    logic [UNIT_W-1:0] rounded;
    logic [PROD_W-1:0] prod;

    assign load      = !valid_reg || core_ready;
    assign req_stall = valid_reg && !core_ready;

    // divide by the alignment through the reciprocal, rounding up
    always_comb
    begin
        rounded                = UNIT_W'(request_size) + ROUND_ADD;
        prod                   = PROD_W'(rounded) * PROD_W'(RECIP);
        req_next.mode          = teaa_mode_t'(mode);
        req_next.units         = prod[SHIFT +: UNIT_W];
        req_next.old_offset    = old_offset;
        req_next.prior_size    = prior_size;
        req_next.keep_present  = keep_present;
        valid_next             = load ? req_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            req_reg <= req_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_req   = req_reg;

endmodule

`default_nettype wire

FILE: hdl/teaa_core.sv
// Arena pointers, allocation decision and result register.
`default_nettype none

module teaa_core #(
    parameter int unsigned MAX_POOL_BYTES = teaa_pkg::DEFAULT_MAX_POOL_BYTES,
    parameter int unsigned ALIGN_BYTES    = teaa_pkg::DEFAULT_ALIGN_BYTES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [teaa_pkg::SIZE_W-1:0] cfg_pool_bytes,
    input  wire logic                        stage_valid,
    input  wire teaa_pkg::teaa_req_t         stage_req,
    output logic                             core_ready,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output teaa_pkg::teaa_rsp_t              rsp
);
    import teaa_pkg::*;

    localparam int unsigned POOL_RESET_I = (MAX_POOL_BYTES < 65536) ? MAX_POOL_BYTES : 65536;
    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(POOL_RESET_I);
    localparam logic [UNIT_W-1:0] ALIGN_U    = UNIT_W'(ALIGN_BYTES);

    logic [SIZE_W-1:0]   pool_reg;
    logic [SIZE_W-1:0]   pool_next;
    logic [SIZE_W-1:0]   front_reg;
    logic [SIZE_W-1:0]   front_next;
    logic [SIZE_W-1:0]   back_reg;
    logic [SIZE_W-1:0]   back_next;
    logic                valid_reg;
    logic                valid_next;
    teaa_rsp_t           rsp_reg;
    teaa_rsp_t           rsp_next;
    logic                fire;
    logic [2*UNIT_W-1:0] asize_prod;
    logic [UNIT_W-1:0]   asize;
    logic [EXT_W-1:0]    f_ext;
    logic [EXT_W-1:0]    b_ext;
    logic [EXT_W-1:0]    a_ext;
    logic [EXT_W-1:0]    os_ext;
    logic [EXT_W-1:0]    oo_ext;
    logic [EXT_W-1:0]    pool_ext;
    logic [EXT_W-1:0]    front_plus;
    logic [EXT_W-1:0]    front_base;
    logic [EXT_W-1:0]    new_front;
    logic                fits_front;
    logic                in_place;
    logic [SIZE_W-1:0]   cfg_sat;

    assign core_ready = !valid_reg || !rsp_stall;
    assign fire       = stage_valid && core_ready;

    always_comb
    begin
        asize_prod = (2*UNIT_W)'(stage_req.units) * (2*UNIT_W)'(ALIGN_U);
        asize      = asize_prod[UNIT_W-1:0];
        f_ext      = EXT_W'(front_reg);
        b_ext      = EXT_W'(back_reg);
        a_ext      = EXT_W'(asize);
        os_ext     = EXT_W'(stage_req.prior_size);
        oo_ext     = EXT_W'(stage_req.old_offset);
        pool_ext   = EXT_W'(pool_reg);
        front_plus = f_ext + a_ext;
        fits_front = front_plus <= b_ext;
        front_base = f_ext - os_ext;
        in_place   = (f_ext >= os_ext) && (front_base == oo_ext);
        new_front  = front_base + a_ext;
        cfg_sat    = (32'(cfg_pool_bytes) > MAX_POOL_BYTES) ? SIZE_W'(MAX_POOL_BYTES)
                                                            : cfg_pool_bytes;
    end

    always_comb
    begin
        rsp_next   = '0;
        front_next = front_reg;
        back_next  = back_reg;
        pool_next  = pool_reg;
        unique case (stage_req.mode)
            MODE_ALLOC_FRONT:
            begin
                if (fits_front)
                begin
                    rsp_next.success = 1'b1;
                    rsp_next.offset  = front_reg;
                    front_next       = front_plus[SIZE_W-1:0];
                end
            end
            MODE_ALLOC_BACK:
            begin
                if (fits_front)
                begin
                    back_next        = back_reg - asize[SIZE_W-1:0];
                    rsp_next.success = 1'b1;
                    rsp_next.offset  = back_next;
                end
            end
            MODE_REALLOC:
            begin
                if (b_ext >= os_ext && b_ext >= a_ext)
                begin
                    if (in_place)
                    begin
                        if (new_front <= b_ext)
                        begin
                            front_next       = new_front[SIZE_W-1:0];
                            rsp_next.success = 1'b1;
                            rsp_next.offset  = SIZE_W'(stage_req.old_offset);
                        end
                    end
                    else if (a_ext <= os_ext)
                    begin
                        rsp_next.success = 1'b1;
                        rsp_next.offset  = SIZE_W'(stage_req.old_offset);
                    end
                    else if (fits_front)
                    begin
                        rsp_next.success     = 1'b1;
                        rsp_next.offset      = front_reg;
                        rsp_next.copy_needed = 1'b1;
                        rsp_next.copy_from   = stage_req.old_offset;
                        rsp_next.copy_length = stage_req.prior_size;
                        front_next           = front_plus[SIZE_W-1:0];
                    end
                end
            end
            MODE_RESET:
            begin
                back_next = pool_reg;
                if (stage_req.keep_present)
                begin
                    front_next       = (a_ext > pool_ext) ? pool_reg : asize[SIZE_W-1:0];
                    rsp_next.success = 1'b1;
                    if (stage_req.old_offset != '0)
                    begin
                        rsp_next.copy_needed = 1'b1;
                        rsp_next.copy_from   = stage_req.old_offset;
                        rsp_next.copy_length = stage_req.prior_size;
                    end
                end
            end
        endcase
        if (!fire)
        begin
            front_next = front_reg;
            back_next  = back_reg;
        end
        // register write restarts the arena
        if (cfg_valid)
        begin
            pool_next  = cfg_sat;
            front_next = '0;
            back_next  = cfg_sat;
        end
        valid_next = fire || (valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= POOL_RESET;
            front_reg <= '0;
            back_reg  <= POOL_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            pool_reg  <= pool_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: hdl/two_ended_arena_allocator_unit.sv
// Two-ended arena allocator: top level.
//
// Request channel (req_valid/req_stall) carries mode, request_size, old_offset,
// prior_size and keep_present. Response channel (rsp_valid/rsp_stall) returns
// success, offset and a copy command (copy_needed, copy_from, copy_length).
// The configuration channel (cfg_valid/cfg_ready) writes pool_bytes, which
// saturates to MAX_POOL_BYTES and restarts the arena; write it only while idle.
// Sizes are rounded up to ALIGN_BYTES in the request register.
// A request passes the request register, then the pointer update and the
// response register in one pass. Throughput is one request per cycle while the
// response is not stalled, set by the read-modify-write of the front and back pointers.
// Reset (rst_n low, asynchronous) empties both registers, sets the arena size
// to min(65536, MAX_POOL_BYTES), front to 0 and back to the arena size.
// A stalled response holds; the request register keeps one more request and
// then raises req_stall until the response is taken.
`default_nettype none

module two_ended_arena_allocator_unit #(
    parameter int unsigned MAX_POOL_BYTES = teaa_pkg::DEFAULT_MAX_POOL_BYTES,
    parameter int unsigned ALIGN_BYTES    = teaa_pkg::DEFAULT_ALIGN_BYTES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [teaa_pkg::SIZE_W-1:0] pool_bytes,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [1:0]                  mode,
    input  wire logic [teaa_pkg::SIZE_W-1:0] request_size,
    input  wire logic [teaa_pkg::OFF_W-1:0]  old_offset,
    input  wire logic [teaa_pkg::SIZE_W-1:0] prior_size,
    input  wire logic                        keep_present,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic                             success,
    output logic [teaa_pkg::SIZE_W-1:0]      offset,
    output logic                             copy_needed,
    output logic [teaa_pkg::OFF_W-1:0]       copy_from,
    output logic [teaa_pkg::SIZE_W-1:0]      copy_length
);
    import teaa_pkg::*;

    logic      core_ready;
    logic      stage_valid;
    teaa_req_t stage_req;
    teaa_rsp_t rsp;

    assign cfg_ready = 1'b1;

    teaa_in_stage #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .mode         (mode),
        .request_size (request_size),
        .old_offset   (old_offset),
        .prior_size   (prior_size),
        .keep_present (keep_present),
        .core_ready   (core_ready),
        .stage_valid  (stage_valid),
        .stage_req    (stage_req)
    );

    teaa_core #(
        .MAX_POOL_BYTES (MAX_POOL_BYTES),
        .ALIGN_BYTES    (ALIGN_BYTES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_pool_bytes (pool_bytes),
        .stage_valid    (stage_valid),
        .stage_req      (stage_req),
        .core_ready     (core_ready),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp)
    );

    assign success     = rsp.success;
    assign offset      = rsp.offset;
    assign copy_needed = rsp.copy_needed;
    assign copy_from   = rsp.copy_from;
    assign copy_length = rsp.copy_length;

    a_fail_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !success |-> offset == '0 && !copy_needed
                                  && copy_from == '0 && copy_length == '0)
        else $error("failed request carries nonzero fields");

    a_no_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !copy_needed |-> copy_from == '0 && copy_length == '0)
        else $error("copy fields set without copy request");

    a_copy_granted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && copy_needed |-> success)
        else $error("copy requested on failed request");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the two-ended arena allocator unit.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import teaa_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned TAIL_CYCLES  = 5;

    typedef struct packed {
        teaa_mode_t          mode;
        logic [SIZE_W-1:0]   request_size;
        logic [OFF_W-1:0]    old_offset;
        logic [SIZE_W-1:0]   prior_size;
        logic                keep_present;
    } arena_request_t;

    class arena_scoreboard;
        int unsigned pool;
        int unsigned front;
        int unsigned back;
        int unsigned errors;
        teaa_rsp_t   grants[$];

        function new();
            pool   = DEFAULT_MAX_POOL_BYTES;
            front  = 0;
            back   = DEFAULT_MAX_POOL_BYTES;
            errors = 0;
        endfunction

        function void set_pool(int unsigned value);
            pool  = (value > DEFAULT_MAX_POOL_BYTES) ? DEFAULT_MAX_POOL_BYTES : value;
            front = 0;
            back  = pool;
        endfunction

        function int unsigned pending();
            return grants.size();
        endfunction

        function void note_request(arena_request_t r);
            int unsigned asize;
            int unsigned osz;
            int unsigned ooff;
            int unsigned next_front;
            teaa_rsp_t   grant;
            asize = ((int'(r.request_size) + DEFAULT_ALIGN_BYTES - 1) / DEFAULT_ALIGN_BYTES)
                    * DEFAULT_ALIGN_BYTES;
            osz   = 32'(r.prior_size);
            ooff  = 32'(r.old_offset);
            grant = '0;
            case (r.mode) inside
                MODE_ALLOC_FRONT, MODE_ALLOC_BACK:
                begin
                    if (front + asize <= back)
                    begin
                        grant.success = 1'b1;
                        if (r.mode == MODE_ALLOC_BACK)
                        begin
                            back         = back - asize;
                            grant.offset = SIZE_W'(back);
                        end
                        else
                        begin
                            grant.offset = SIZE_W'(front);
                            front        = front + asize;
                        end
                    end
                end
                MODE_REALLOC:
                begin
                    if (back >= osz && back >= asize)
                    begin
                        if (front >= osz && front - osz == ooff)
                        begin
                            next_front = front - osz + asize;
                            if (next_front <= back)
                            begin
                                front         = next_front;
                                grant.success = 1'b1;
                                grant.offset  = SIZE_W'(ooff);
                            end
                        end
                        else if (asize <= osz)
                        begin
                            grant.success = 1'b1;
                            grant.offset  = SIZE_W'(ooff);
                        end
                        else if (front + asize <= back)
                        begin
                            grant.success     = 1'b1;
                            grant.offset      = SIZE_W'(front);
                            grant.copy_needed = 1'b1;
                            grant.copy_from   = OFF_W'(ooff);
                            grant.copy_length = SIZE_W'(osz);
                            front             = front + asize;
                        end
                    end
                end
                default:
                begin
                    back = pool;
                    if (r.keep_present)
                    begin
                        front         = (asize > pool) ? pool : asize;
                        grant.success = 1'b1;
                        if (ooff != 0)
                        begin
                            grant.copy_needed = 1'b1;
                            grant.copy_from   = OFF_W'(ooff);
                            grant.copy_length = SIZE_W'(osz);
                        end
                    end
                end
            endcase
            grants.push_back(grant);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                errors++;
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
            end
        endfunction

        function void check_response(teaa_rsp_t got);
            teaa_rsp_t want;
            if (grants.size() == 0)
            begin
                errors++;
                $display("%0t unexpected response: expected none, actual offset %0d",
                         $time, got.offset);
                return;
            end
            want = grants.pop_front();
            compare_field("success", 32'(want.success), 32'(got.success));
            compare_field("offset", 32'(want.offset), 32'(got.offset));
            compare_field("copy_needed", 32'(want.copy_needed), 32'(got.copy_needed));
            compare_field("copy_from", 32'(want.copy_from), 32'(got.copy_from));
            compare_field("copy_length", 32'(want.copy_length), 32'(got.copy_length));
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] pool_bytes   = '0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    logic [1:0]        mode         = '0;
    logic [SIZE_W-1:0] request_size = '0;
    logic [OFF_W-1:0]  old_offset   = '0;
    logic [SIZE_W-1:0] prior_size   = '0;
    logic              keep_present = 1'b0;
    logic              rsp_valid;
    logic              rsp_stall    = 1'b0;
    logic              success;
    logic [SIZE_W-1:0] offset;
    logic              copy_needed;
    logic [OFF_W-1:0]  copy_from;
    logic [SIZE_W-1:0] copy_length;

    bit                steady = 1'b0;
    arena_scoreboard   sb = new();

    two_ended_arena_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .pool_bytes   (pool_bytes),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .mode         (mode),
        .request_size (request_size),
        .old_offset   (old_offset),
        .prior_size   (prior_size),
        .keep_present (keep_present),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .success      (success),
        .offset       (offset),
        .copy_needed  (copy_needed),
        .copy_from    (copy_from),
        .copy_length  (copy_length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response('{success, offset, copy_needed, copy_from, copy_length});
        rsp_stall <= !steady && ($urandom_range(0, 99) < 21);
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL two_ended_arena_allocator_unit");
        $finish;
    end

    function automatic arena_request_t make_request(teaa_mode_t m, int unsigned rs,
                                                    int unsigned oo, int unsigned os, bit k);
        arena_request_t r;
        r.mode         = m;
        r.request_size = SIZE_W'(rs);
        r.old_offset   = OFF_W'(oo);
        r.prior_size   = SIZE_W'(os);
        r.keep_present = k;
        return r;
    endfunction

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 1024);
        else if (roll < 95)
            return $urandom_range(0, 16384);
        return $urandom_range(0, 131071);
    endfunction

    function automatic arena_request_t random_request();
        int unsigned roll;
        int unsigned osz;
        int unsigned span;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return make_request(MODE_ALLOC_FRONT, pick_size(), $urandom, $urandom,
                                1'($urandom_range(0, 1)));
        if (roll < 50)
            return make_request(MODE_ALLOC_BACK, pick_size(), $urandom, $urandom,
                                1'($urandom_range(0, 1)));
        if (roll < 65)
        begin
            span = (sb.front > 2048) ? 2048 : sb.front;
            osz  = $urandom_range(0, span);
            if ($urandom_range(0, 1))
                osz = osz & ~(DEFAULT_ALIGN_BYTES - 1);
            return make_request(MODE_REALLOC, pick_size(), sb.front - osz, osz, 1'b0);
        end
        if (roll < 73)
        begin
            osz = pick_size();
            return make_request(MODE_REALLOC, $urandom_range(0, osz), $urandom_range(0, 65535),
                                osz, 1'($urandom_range(0, 1)));
        end
        if (roll < 80)
            return make_request(MODE_REALLOC, pick_size(), $urandom_range(0, 65535),
                                pick_size(), 1'b0);
        if (roll < 90)
            return make_request(MODE_RESET, pick_size(),
                                $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535),
                                pick_size(), 1'($urandom_range(0, 1)));
        return make_request(teaa_mode_t'($urandom_range(0, 3)), $urandom_range(0, 131071),
                            $urandom_range(0, 65535), $urandom_range(0, 131071),
                            1'($urandom_range(0, 1)));
    endfunction

    task automatic send_request(arena_request_t r);
        while (!steady && $urandom_range(0, 99) < 21)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        mode         <= r.mode;
        request_size <= r.request_size;
        old_offset   <= r.old_offset;
        prior_size   <= r.prior_size;
        keep_present <= r.keep_present;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool(int unsigned value);
        cfg_valid  <= 1'b1;
        pool_bytes <= SIZE_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_pool(value);
    endtask

    initial
    begin
        int unsigned pool_plan[7];
        pool_plan = '{65536, 0, 256, 131071, $urandom_range(0, 131071), 4096,
                      $urandom_range(1024, 65536)};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(MODE_ALLOC_FRONT, 0, 0, 0, 0));
        send_request(make_request(MODE_ALLOC_FRONT, 1, 0, 0, 0));
        send_request(make_request(MODE_ALLOC_FRONT, 17, 0, 0, 0));
        send_request(make_request(MODE_ALLOC_BACK, 100, 0, 0, 0));
        send_request(make_request(MODE_ALLOC_BACK, 0, 0, 0, 0));
        send_request(make_request(MODE_REALLOC, 64, sb.front - 32, 32, 0));
        send_request(make_request(MODE_REALLOC, 8, sb.front - 64, 64, 0));
        send_request(make_request(MODE_REALLOC, 16, 4096, 48, 0));
        send_request(make_request(MODE_REALLOC, 200, 0, 16, 0));
        send_request(make_request(MODE_REALLOC, 16, 0, 131071, 0));
        send_request(make_request(MODE_REALLOC, 131071, 0, 16, 0));
        send_request(make_request(MODE_REALLOC, 65000, 0, 16, 0));
        send_request(make_request(MODE_REALLOC, 65535, sb.front - 16, 16, 0));
        send_request(make_request(MODE_ALLOC_FRONT, 131071, 65535, 131071, 1));
        send_request(make_request(MODE_ALLOC_BACK, 65536, 0, 0, 0));
        send_request(make_request(MODE_ALLOC_FRONT, sb.back - sb.front, 0, 0, 0));
        send_request(make_request(MODE_ALLOC_FRONT, 1, 0, 0, 0));
        send_request(make_request(MODE_RESET, 48, 16, 48, 1));
        send_request(make_request(MODE_RESET, 33, 0, 40, 1));
        send_request(make_request(MODE_RESET, 500, 123, 77, 0));
        send_request(make_request(MODE_RESET, 131071, 65535, 65536, 1));
        send_request(make_request(MODE_ALLOC_BACK, 16, 0, 0, 0));
        send_request(make_request(MODE_RESET, 0, 0, 0, 1));
        send_request(make_request(MODE_ALLOC_FRONT, 65536, 0, 0, 0));
        send_request(make_request(MODE_RESET, 0, 0, 0, 1));

        foreach (pool_plan[p])
        begin
            drain_responses();
            write_pool(pool_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                steady = (p == 0) && (i >= 20) && (i < 90);
                if (p == 0 && i == 50)
                    drain_responses();
                send_request(random_request());
            end
            steady = 1'b0;
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS two_ended_arena_allocator_unit");
        else
            $display("FAIL two_ended_arena_allocator_unit");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/teaa_pkg.sv
hdl/teaa_in_stage.sv
hdl/teaa_core.sv
hdl/two_ended_arena_allocator_unit.sv
sim/testbench.sv
